/* src/chained_hash_index_table_defines.svh */
// ----------------------------------------------------------------------------
// chained hash index table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_INDEX_TABLE_DEFINES_SVH
`define CHAINED_HASH_INDEX_TABLE_DEFINES_SVH

// antecedent and consequent on the same edge
`define CHIT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent on the edge after the antecedent
`define CHIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/chit_pkg.sv */
// ----------------------------------------------------------------------------
// chit_pkg
// types, codes and constants shared by the chained hash index table
// ----------------------------------------------------------------------------
package chit_pkg;

   localparam int IDX_W  = 11;
   localparam int KEY_W  = 32;
   localparam int MODE_W = 3;
   localparam int MASK_W = 8;

   localparam int BUCKET_DEPTH_DEF = 256;
   localparam int ENTRY_DEPTH_DEF  = 1024;

   localparam logic [IDX_W-1:0]  NULL_IDX    = '1;
   localparam logic [MASK_W-1:0] MASK_RESET  = 8'hFF;
   localparam logic [IDX_W-1:0]  LIMIT_RESET = 11'd1024;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MASK  = 1'b0;
   localparam logic CSR_IDX_LIMIT = 1'b1;

   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd4;

   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [IDX_W-1:0]  entry;
   } req_item_type;

   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] found_entry;
   } rsp_item_type;

   typedef enum logic [1:0] {
      HW_NONE,
      HW_ENTRY,
      HW_LINK,
      HW_SWEEP
   } head_wr_type;

   typedef enum logic [1:0] {
      LW_NONE,
      LW_HEAD,
      LW_NULL,
      LW_SPLICE
   } link_wr_type;

   typedef enum logic [1:0] {
      FS_NULL,
      FS_HEAD,
      FS_LINK
   } found_sel_type;

   typedef struct packed {
      logic          cap_req;
      head_wr_type   head_wr;
      link_wr_type   link_wr;
      logic          link_rd_cur;
      logic          walk_load;
      logic          walk_step;
      logic          clr_load;
      logic          emit;
      logic          emit_status;
      found_sel_type found_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              entry_ok;
      logic              head_hit;
      logic              link_hit;
      logic              walk_stop;
      logic              clr_last;
   } dp_sts_type;

endpackage

/* src/chit_ram.sv */
// ----------------------------------------------------------------------------
// chit_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module chit_ram
   import chit_pkg::*;
#(
   parameter int WIDTH = IDX_W,
   parameter int DEPTH = BUCKET_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/chit_ctrl.sv */
// ----------------------------------------------------------------------------
// chit_ctrl
// sequencer for decode, execute, chain walk and head clearing sweep
// ----------------------------------------------------------------------------
module chit_ctrl
   import chit_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  dp_sts_type sts,
   output logic       busy,
   output dp_cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DECODE   = 7'b0000010,
      ST_EXEC     = 7'b0000100,
      ST_CLEAR    = 7'b0001000,
      ST_WALK_CHK = 7'b0010000,
      ST_WALK_CMP = 7'b0100000,
      ST_REM_END  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      report_ff, report_in;
   logic      done;

   always_comb begin
      state_in        = state_ff;
      report_in       = report_ff;
      busy            = 1'b1;
      done            = 1'b0;
      cmd.cap_req     = 1'b0;
      cmd.head_wr     = HW_NONE;
      cmd.link_wr     = LW_NONE;
      cmd.link_rd_cur = 1'b0;
      cmd.walk_load   = 1'b0;
      cmd.walk_step   = 1'b0;
      cmd.clr_load    = 1'b0;
      cmd.emit        = 1'b0;
      cmd.emit_status = STATUS_DONE;
      cmd.found_sel   = FS_NULL;

      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.cap_req = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (sts.mode)
               MODE_ADD: begin
                  if (sts.entry_ok) begin
                     cmd.head_wr = HW_ENTRY;
                     cmd.link_wr = LW_HEAD;
                  end else begin
                     cmd.emit_status = STATUS_REJECTED;
                  end
                  cmd.emit = 1'b1;
                  done     = 1'b1;
               end
               MODE_REMOVE: begin
                  if (!sts.entry_ok) begin
                     cmd.emit_status = STATUS_REJECTED;
                     cmd.emit        = 1'b1;
                     done            = 1'b1;
                  end else if (sts.head_hit) begin
                     cmd.head_wr = HW_LINK;
                     cmd.link_wr = LW_NULL;
                     cmd.emit    = 1'b1;
                     done        = 1'b1;
                  end else begin
                     cmd.walk_load = 1'b1;
                     state_in      = ST_WALK_CHK;
                  end
               end
               MODE_FIRST: begin
                  cmd.found_sel = FS_HEAD;
                  cmd.emit      = 1'b1;
                  done          = 1'b1;
               end
               MODE_NEXT: begin
                  cmd.found_sel = sts.entry_ok ? FS_LINK : FS_NULL;
                  cmd.emit      = 1'b1;
                  done          = 1'b1;
               end
               MODE_FLUSH: begin
                  cmd.clr_load = 1'b1;
                  report_in    = 1'b1;
                  state_in     = ST_CLEAR;
               end
               default: begin
                  cmd.emit = 1'b1;
                  done     = 1'b1;
               end
            endcase
            if (done) begin
               busy = 1'b0;
               if (start) begin
                  cmd.cap_req = 1'b1;
                  state_in    = ST_DECODE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CLEAR: begin
            cmd.head_wr = HW_SWEEP;
            if (sts.clr_last) begin
               cmd.emit  = report_ff;
               report_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         ST_WALK_CHK: begin
            if (sts.walk_stop) begin
               cmd.link_wr = LW_NULL;
               cmd.emit    = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.link_rd_cur = 1'b1;
               state_in        = ST_WALK_CMP;
            end
         end
         ST_WALK_CMP: begin
            if (sts.link_hit) begin
               cmd.link_wr = LW_SPLICE;
               state_in    = ST_REM_END;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = ST_WALK_CHK;
            end
         end
         ST_REM_END: begin
            cmd.link_wr = LW_NULL;
            cmd.emit    = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         report_ff <= report_in;
      end
   end

endmodule

/* src/chit_dpath.sv */
// ----------------------------------------------------------------------------
// chit_dpath
// head and link memories, bucket decode, walk registers, csr and result
// ----------------------------------------------------------------------------
module chit_dpath
   import chit_pkg::*;
#(
   parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
   parameter int ENTRY_DEPTH  = ENTRY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_item_type          req_item,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic                  csr_wr,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_item
);

   localparam int BW     = $clog2(BUCKET_DEPTH);
   localparam int EW     = $clog2(ENTRY_DEPTH);
   localparam int STEP_W = $clog2(ENTRY_DEPTH + 1);

   req_item_type      req_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [IDX_W-1:0]  limit_ff;
   logic [IDX_W-1:0]  cur_ff;
   logic [IDX_W-1:0]  succ_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [BW-1:0]     clr_cnt_ff;
   logic              rsp_strobe_ff;
   rsp_item_type      rsp_item_ff;

   logic [MASK_W-1:0] red_v;
   logic [BW-1:0]     bucket;
   logic [EW-1:0]     e_addr;
   logic [EW-1:0]     cur_addr;
   logic              cur_ok;

   logic             head_we;
   logic [BW-1:0]    head_waddr;
   logic [IDX_W-1:0] head_wdata;
   logic [IDX_W-1:0] head_q;
   logic             link_we;
   logic [EW-1:0]    link_waddr;
   logic [IDX_W-1:0] link_wdata;
   logic [EW-1:0]    link_raddr;
   logic [IDX_W-1:0] link_q;
   logic [IDX_W-1:0] found;

   // masked bucket folded into the table depth, restoring subtract per bit
   always_comb begin
      red_v = req_ff.key[MASK_W-1:0] & mask_ff;
      for (int k = MASK_W - 1; k >= 0; k--) begin
         if (32'(red_v) >= (BUCKET_DEPTH << k)) begin
            red_v = red_v - MASK_W'(BUCKET_DEPTH << k);
         end
      end
   end

   assign bucket   = BW'(red_v);
   assign e_addr   = EW'(req_ff.entry);
   assign cur_addr = EW'(cur_ff);
   assign cur_ok   = (cur_ff < limit_ff) && (32'(cur_ff) < ENTRY_DEPTH);

   assign sts.mode      = req_ff.mode;
   assign sts.entry_ok  = (req_ff.entry < limit_ff) && (32'(req_ff.entry) < ENTRY_DEPTH);
   assign sts.head_hit  = (head_q == req_ff.entry);
   assign sts.link_hit  = (link_q == req_ff.entry);
   assign sts.walk_stop = !cur_ok || (steps_ff == STEP_W'(ENTRY_DEPTH));
   assign sts.clr_last  = (clr_cnt_ff == BW'(BUCKET_DEPTH - 1));

   always_comb begin
      head_we    = 1'b1;
      head_waddr = bucket;
      head_wdata = NULL_IDX;
      case (cmd.head_wr)
         HW_ENTRY: head_wdata = req_ff.entry;
         HW_LINK:  head_wdata = link_q;
         HW_SWEEP: head_waddr = clr_cnt_ff;
         default:  head_we    = 1'b0;
      endcase
   end

   always_comb begin
      link_we    = 1'b1;
      link_waddr = e_addr;
      link_wdata = NULL_IDX;
      case (cmd.link_wr)
         LW_HEAD:   link_wdata = head_q;
         LW_NULL:   link_wdata = NULL_IDX;
         LW_SPLICE: begin
            link_waddr = cur_addr;
            link_wdata = succ_ff;
         end
         default:   link_we = 1'b0;
      endcase
   end

   assign link_raddr = cmd.link_rd_cur ? cur_addr : e_addr;

   chit_ram #(
      .WIDTH (IDX_W),
      .DEPTH (BUCKET_DEPTH)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (bucket),
      .rd_data (head_q)
   );

   chit_ram #(
      .WIDTH (IDX_W),
      .DEPTH (ENTRY_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_q)
   );

   always_comb begin
      case (cmd.found_sel)
         FS_HEAD: found = head_q;
         FS_LINK: found = link_q;
         default: found = NULL_IDX;
      endcase
   end

   always_comb begin
      case (paddr[2])
         CSR_IDX_LIMIT: prdata = CSR_DATA_W'(limit_ff);
         default:       prdata = CSR_DATA_W'(mask_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= MASK_RESET;
         limit_ff      <= LIMIT_RESET;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (paddr[2])
               CSR_IDX_MASK:  mask_ff  <= pwdata[MASK_W-1:0];
               CSR_IDX_LIMIT: limit_ff <= pwdata[IDX_W-1:0];
               default:       mask_ff  <= mask_ff;
            endcase
         end
         if (cmd.clr_load) begin
            clr_cnt_ff <= '0;
         end else if (cmd.head_wr == HW_SWEEP) begin
            clr_cnt_ff <= clr_cnt_ff + BW'(1);
         end
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         req_ff <= req_item;
      end
      if (cmd.walk_load) begin
         cur_ff   <= head_q;
         succ_ff  <= link_q;
         steps_ff <= '0;
      end else if (cmd.walk_step) begin
         cur_ff   <= link_q;
         steps_ff <= steps_ff + STEP_W'(1);
      end
      if (cmd.emit) begin
         rsp_item_ff.status      <= cmd.emit_status;
         rsp_item_ff.found_entry <= found;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

/* src/chained_hash_index_table.sv */
// ----------------------------------------------------------------------------
// chained_hash_index_table
// add, first, next and unused modes: decode read, then execute, with the
//   result strobe registered from execute; a new item can be taken in execute
// remove: done in execute on a head hit, else the chain is walked link by link,
//   paced by the single read port of the link ram
// flush: a sweep over the head ram, one head ram entry cleared per cycle
// reset: head clearing pass with busy high, csr writes taken
// ----------------------------------------------------------------------------
module chained_hash_index_table
   import chit_pkg::*;
#(
   parameter int BUCKET_DEPTH = BUCKET_DEPTH_DEF,
   parameter int ENTRY_DEPTH  = ENTRY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input, taken when start is high and busy is low
   input  logic                  start,
   output logic                  busy,
   input  req_item_type          req_item,
   // result item, valid for the single cycle rsp_strobe is high
   output logic                  rsp_strobe,
   output rsp_item_type          rsp_item,
   // apb style csr port: bucket_mask at 0, entry_limit at 4
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       csr_wr;

   // no wait states on the csr port
   assign pready = 1'b1;

   // write completes on the access phase
   assign csr_wr = psel && penable && pwrite && pready;

   // sequencer: idle, decode read, execute, chain walk, clearing sweep
   chit_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .busy  (busy),
      .cmd   (cmd)
   );

   // memories, bucket fold, walk pointers, csr registers and result register
   chit_dpath #(
      .BUCKET_DEPTH (BUCKET_DEPTH),
      .ENTRY_DEPTH  (ENTRY_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .csr_wr     (csr_wr),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

/* src/chit_checker.sv */
// ----------------------------------------------------------------------------
// chit_checker
// port level checks on item acceptance and result timing
// ----------------------------------------------------------------------------
`include "chained_hash_index_table_defines.svh"

module chit_checker
   import chit_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_strobe,
   input rsp_item_type rsp_item
);

   logic acc;

   assign acc = start && !busy;

   // an accepted item keeps the block busy through decode
   `CHIT_ASSERT_NEXT(a_busy_after_accept, clock, reset, acc, busy, "busy low after accept")

   // results never come on back to back cycles
   `CHIT_ASSERT_NEXT(a_strobe_spacing, clock, reset, rsp_strobe, !rsp_strobe, "back to back strobes")

   // an accepted add of the null index is rejected once decode and execute have passed
   `CHIT_ASSERT_SAME(a_null_add_rejected, clock, reset, acc && (req_item.mode == MODE_ADD) && (req_item.entry == NULL_IDX), ##3 (rsp_strobe && (rsp_item.status == STATUS_REJECTED)), "null add not rejected")

   // a rejected item carries the null index
   `CHIT_ASSERT_SAME(a_reject_null, clock, reset, rsp_strobe && (rsp_item.status == STATUS_REJECTED), rsp_item.found_entry == NULL_IDX, "rejected item with index")

endmodule

bind chained_hash_index_table chit_checker u_chit_checker (.*);
